>>> sv/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, request codes, GF(2^8) xt and S-box tables for the AES core.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

	typedef logic [127:0] block_t;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_ENC  = 2'd1;
	localparam logic [1:0] REQ_DEC  = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [7:0] REDUCTION = 8'h1b;
	localparam int unsigned NUM_KEYS = 11;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_ROUND = 2'b10
	} state_t;

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? REDUCTION : 8'h00);
	endfunction

	localparam logic [7:0] SBOX_FWD [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

endpackage
`default_nettype wire

>>> sv/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// Shared round unit: one forward or inverse AES round per cycle on a state
// word. Byte 0 sits in bits 127:120, byte i is row i%4 of column i/4.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round (
	input  wire aes_pkg::block_t state_in,
	input  wire aes_pkg::block_t round_key,
	input  wire                  inverse,
	input  wire                  last,
	output aes_pkg::block_t      state_out
);

	logic [7:0] s   [16];
	logic [7:0] sh  [16];
	logic [7:0] sb  [16];
	logic [7:0] pre [16];
	logic [7:0] mx  [16];
	logic [7:0] rk  [16];
	logic [7:0] res [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i]  = state_in[8*(15-i) +: 8];
			rk[i] = round_key[8*(15-i) +: 8];
		end
		// shift rows, then substitute (order is immaterial as both are bytewise)
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sh[c*4+r] = inverse ? s[((c - r + 4) % 4)*4 + r] : s[((c + r) % 4)*4 + r];
			end
		end
		for (int i = 0; i < 16; i++) begin
			sb[i] = inverse ? aes_pkg::SBOX_INV[sh[i]] : aes_pkg::SBOX_FWD[sh[i]];
		end
		// forward mixes before the key, inverse adds the key first
		for (int i = 0; i < 16; i++) begin
			pre[i] = inverse ? (sb[i] ^ rk[i]) : sb[i];
		end
		// inverse: 4*(a0^a2) / 4*(a1^a3) correction ahead of MixColumns
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, u, v;
			a0 = pre[c*4];
			a1 = pre[c*4+1];
			a2 = pre[c*4+2];
			a3 = pre[c*4+3];
			u = aes_pkg::xt(aes_pkg::xt(a0 ^ a2));
			v = aes_pkg::xt(aes_pkg::xt(a1 ^ a3));
			if (inverse) begin
				a0 = a0 ^ u;
				a2 = a2 ^ u;
				a1 = a1 ^ v;
				a3 = a3 ^ v;
			end
			mx[c*4]   = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
			mx[c*4+1] = aes_pkg::xt(a1) ^ aes_pkg::xt(a2) ^ a2 ^ a3 ^ a0;
			mx[c*4+2] = aes_pkg::xt(a2) ^ aes_pkg::xt(a3) ^ a3 ^ a0 ^ a1;
			mx[c*4+3] = aes_pkg::xt(a3) ^ aes_pkg::xt(a0) ^ a0 ^ a1 ^ a2;
		end
		for (int i = 0; i < 16; i++) begin
			if (inverse) begin
				res[i] = last ? pre[i] : mx[i];
			end else begin
				res[i] = (last ? sb[i] : mx[i]) ^ rk[i];
			end
			state_out[8*(15-i) +: 8] = res[i];
		end
	end

endmodule
`default_nettype wire

>>> sv/aes128_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit
// AES-128 encrypt/decrypt on a preloaded key schedule, one round per cycle.
// ----------------------------------------------------------------------------
// Load words are written to the key store on accept and give no result.
// A block word: initial key add on accept, then ten rounds through one shared
// round unit, one per cycle, the last held while a full output is stalled; no
// new word is taken until the result is written to the output register.
// A result left waiting in the output register holds the final round.
// Reset clears control state only; round keys are undefined until loaded.
`default_nettype none
module aes128_block_cipher_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  req_type,
	input  wire  [3:0]  key_round,
	input  wire  [63:0] data_hi,
	input  wire  [63:0] data_lo,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo
);

	aes_pkg::state_t state_q;
	aes_pkg::block_t key_mem [aes_pkg::NUM_KEYS];
	aes_pkg::block_t blk_q;
	aes_pkg::block_t rk_q;
	aes_pkg::block_t next_blk;
	aes_pkg::block_t out_q;
	logic [3:0]      rnd_q;
	logic            inv_q;
	logic            out_valid_q;
	logic            in_acc;
	logic            is_blk;
	logic [3:0]      rd_idx;
	logic [3:0]      first_idx;
	logic            last;
	logic            out_free;
	logic            round_done;

	assign in_stall   = !(state_q == aes_pkg::ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign is_blk     = (req_type == aes_pkg::REQ_ENC) || (req_type == aes_pkg::REQ_DEC);
	assign last       = (rnd_q == 4'd10);
	assign out_free   = !out_valid_q || !out_stall;
	assign round_done = (state_q == aes_pkg::ST_ROUND) && last && out_free;

	// next key index to fetch
	always_comb begin
		if (state_q == aes_pkg::ST_IDLE) begin
			rd_idx = (req_type == aes_pkg::REQ_DEC) ? 4'd9 : 4'd1;
		end else begin
			rd_idx = inv_q ? (4'd9 - rnd_q) : (rnd_q + 4'd1);
		end
	end

	// key store: write on load, registered read for the next round
	always_ff @(posedge clk) begin
		if (in_acc && req_type == aes_pkg::REQ_LOAD && key_round < 4'd11) begin
			key_mem[key_round] <= {data_hi, data_lo};
		end
		if (rd_idx < 4'd11) begin
			rk_q <= key_mem[rd_idx];
		end
	end

	aes_round u_round (
		.state_in  (blk_q),
		.round_key (rk_q),
		.inverse   (inv_q),
		.last      (last),
		.state_out (next_blk)
	);

	// initial key add is done with the key mem read in the accept cycle
	assign first_idx = (req_type == aes_pkg::REQ_DEC) ? 4'd10 : 4'd0;

	always_ff @(posedge clk) begin
		if (in_acc && is_blk) begin
			blk_q <= {data_hi, data_lo} ^ key_mem[first_idx];
		end else if (state_q == aes_pkg::ST_ROUND && !last) begin
			blk_q <= next_blk;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			rnd_q   <= 4'd0;
			inv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				aes_pkg::ST_IDLE: begin
					if (in_acc && is_blk) begin
						state_q <= aes_pkg::ST_ROUND;
						rnd_q   <= 4'd1;
						inv_q   <= (req_type == aes_pkg::REQ_DEC);
					end
				end
				aes_pkg::ST_ROUND: begin
					if (!last) begin
						rnd_q <= rnd_q + 4'd1;
					end else if (out_free) begin
						state_q <= aes_pkg::ST_IDLE;
					end
				end
				default: state_q <= aes_pkg::ST_IDLE;
			endcase
		end
	end

	// output register: final round lands here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (round_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (round_done) begin
			out_q <= next_blk;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hi    = out_q[127:64];
	assign out_lo    = out_q[63:0];

endmodule
`default_nettype wire

>>> tb/aes128_block_cipher_unit_check.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit_check
// Scoreboard for the AES-128 core: tracks accepted words on the input
// channel, works out each cipher result with its own AES-128 model and round
// key copy, and compares every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_block_cipher_unit_check (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  req_type,
	input  wire  [3:0]  key_round,
	input  wire  [63:0] data_hi,
	input  wire  [63:0] data_lo,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [63:0] out_hi,
	input  wire  [63:0] out_lo,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] state_bytes_t [16];

	aes_pkg::block_t key_copy [aes_pkg::NUM_KEYS];
	aes_pkg::block_t cipher_q [$];

	assign outstanding = cipher_q.size();

	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? aes_pkg::REDUCTION : 8'h00);
	endfunction

	function automatic state_bytes_t to_bytes(input aes_pkg::block_t b);
		state_bytes_t s;
		for (int i = 0; i < 16; i++) s[i] = b[127 - 8*i -: 8];
		return s;
	endfunction

	function automatic aes_pkg::block_t from_bytes(input state_bytes_t s);
		aes_pkg::block_t b;
		for (int i = 0; i < 16; i++) b[127 - 8*i -: 8] = s[i];
		return b;
	endfunction

	function automatic state_bytes_t add_rk(input state_bytes_t s, input int r);
		state_bytes_t k;
		k = to_bytes(key_copy[r]);
		for (int i = 0; i < 16; i++) s[i] ^= k[i];
		return s;
	endfunction

	function automatic state_bytes_t subst(input state_bytes_t s, input bit inv);
		for (int i = 0; i < 16; i++)
			s[i] = inv ? aes_pkg::SBOX_INV[s[i]] : aes_pkg::SBOX_FWD[s[i]];
		return s;
	endfunction

	// byte i is row i%4 of column i/4
	function automatic state_bytes_t rows_shift(input state_bytes_t s, input bit inv);
		state_bytes_t t;
		int src;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
				t[c*4 + r] = s[src*4 + r];
			end
		return t;
	endfunction

	function automatic state_bytes_t col_mix(input state_bytes_t s);
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
			s[c*4]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
			s[c*4+1] = gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3 ^ a0;
			s[c*4+2] = gf_dbl(a2) ^ gf_dbl(a3) ^ a3 ^ a0 ^ a1;
			s[c*4+3] = gf_dbl(a3) ^ gf_dbl(a0) ^ a0 ^ a1 ^ a2;
		end
		return s;
	endfunction

	// inverse mix as a 4*(a0^a2), 4*(a1^a3) correction then forward mix
	function automatic state_bytes_t col_unmix(input state_bytes_t s);
		logic [7:0] u, v;
		for (int c = 0; c < 4; c++) begin
			u = gf_dbl(gf_dbl(s[c*4] ^ s[c*4+2]));
			v = gf_dbl(gf_dbl(s[c*4+1] ^ s[c*4+3]));
			s[c*4] ^= u; s[c*4+2] ^= u;
			s[c*4+1] ^= v; s[c*4+3] ^= v;
		end
		return col_mix(s);
	endfunction

	function automatic aes_pkg::block_t cipher_block(input aes_pkg::block_t b,
			input bit decrypt);
		state_bytes_t s;
		s = to_bytes(b);
		if (!decrypt) begin
			s = add_rk(s, 0);
			for (int r = 1; r < 10; r++)
				s = add_rk(col_mix(rows_shift(subst(s, 0), 0)), r);
			s = add_rk(rows_shift(subst(s, 0), 0), 10);
		end else begin
			s = add_rk(s, 10);
			for (int r = 9; r > 0; r--)
				s = col_unmix(add_rk(subst(rows_shift(s, 1), 1), r));
			s = add_rk(subst(rows_shift(s, 1), 1), 0);
		end
		return from_bytes(s);
	endfunction

	// input side: key loads update the copy, blocks queue their result
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			case (req_type)
				aes_pkg::REQ_LOAD:
					if (key_round < aes_pkg::NUM_KEYS) key_copy[key_round] = {data_hi, data_lo};
				aes_pkg::REQ_ENC:
					cipher_q.push_back(cipher_block({data_hi, data_lo}, 1'b0));
				aes_pkg::REQ_DEC:
					cipher_q.push_back(cipher_block({data_hi, data_lo}, 1'b1));
				default: ;
			endcase
		end
	end

	// output side: compare against the oldest expected word
	always @(posedge clk) begin
		aes_pkg::block_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cipher_q.size() == 0) begin
				$error("unexpected result word %h_%h", out_hi, out_lo);
				fail_count++;
			end else begin
				want = cipher_q.pop_front();
				if (out_hi !== want[127:64]) begin
					$error("out_hi expected %h actual %h", want[127:64], out_hi);
					fail_count++;
				end
				if (out_lo !== want[63:0]) begin
					$error("out_lo expected %h actual %h", want[63:0], out_lo);
					fail_count++;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/aes128_block_cipher_unit_test.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit_test
// Stimulus and verdict for the AES-128 core: loads a key schedule, runs
// directed and random encrypt, decrypt and load words under varying idle and
// stall patterns, and leaves checking to the scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_block_cipher_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = aes_pkg::REQ_LOAD;
	logic [3:0]  key_round = '0;
	logic [63:0] data_hi = '0;
	logic [63:0] data_lo = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] out_hi;
	logic [63:0] out_lo;
	int          fail_count;
	int          outstanding;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          holdoff_req = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	aes128_block_cipher_unit dut (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .key_round,
		.data_hi, .data_lo, .out_valid, .out_stall, .out_hi, .out_lo
	);

	aes128_block_cipher_unit_check chk (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .key_round,
		.data_hi, .data_lo, .out_valid, .out_stall, .out_hi, .out_lo,
		.fail_count, .outstanding
	);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// offer one word after a random gap, return once it is accepted
	task automatic send_word(input logic [1:0] t, input logic [3:0] k,
			input logic [63:0] hi, input logic [63:0] lo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= t;
		key_round <= k;
		data_hi   <= hi;
		data_lo   <= lo;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// random phase: mostly blocks on a loaded schedule, some key reloads and noise
	task automatic random_phase(input int n_words);
		int done;
		int pick;
		done = 0;
		while (done < n_words) begin
			pick = $urandom_range(99);
			if (pick < 32) begin
				send_word(aes_pkg::REQ_ENC, 4'($urandom_range(15)), rand64(), rand64());
				done++;
			end else if (pick < 64) begin
				send_word(aes_pkg::REQ_DEC, 4'($urandom_range(15)), rand64(), rand64());
				done++;
			end else if (pick < 88) begin
				send_word(aes_pkg::REQ_LOAD, 4'($urandom_range(10)), rand64(), rand64());
				done++;
			end else if (pick < 95) begin
				send_word(aes_pkg::REQ_LOAD, 4'($urandom_range(15, 11)), rand64(), rand64());
			end else begin
				send_word(aes_pkg::REQ_NONE, 4'($urandom_range(15)), rand64(), rand64());
			end
		end
	endtask

	// receiver: random stall, with one long hold-off on request
	initial begin
		int cnt;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				out_stall <= 1'b1;
				cnt = 0;
				while (cnt < 400) begin
					@(posedge clk);
					cnt++;
				end
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// watchdog
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full schedule with extreme first and last keys
		send_word(aes_pkg::REQ_LOAD, 4'd0, '0, '0);
		for (int r = 1; r < 10; r++) send_word(aes_pkg::REQ_LOAD, 4'(r), rand64(), rand64());
		send_word(aes_pkg::REQ_LOAD, 4'd10, '1, '1);
		send_word(aes_pkg::REQ_ENC, 4'd0, '0, '0);
		send_word(aes_pkg::REQ_ENC, 4'd15, '1, '1);
		send_word(aes_pkg::REQ_DEC, 4'd0, '0, '0);
		send_word(aes_pkg::REQ_DEC, 4'd15, '1, '1);
		// loads beyond the last index and the spare request code are dropped
		send_word(aes_pkg::REQ_LOAD, 4'd11, '1, '1);
		send_word(aes_pkg::REQ_LOAD, 4'd15, '1, '0);
		send_word(aes_pkg::REQ_NONE, 4'd15, '1, '1);
		send_word(aes_pkg::REQ_ENC, 4'd5, rand64(), rand64());
		// swap the extreme keys and run again
		send_word(aes_pkg::REQ_LOAD, 4'd0, '1, '1);
		send_word(aes_pkg::REQ_LOAD, 4'd10, '0, '0);
		send_word(aes_pkg::REQ_DEC, 4'd3, rand64(), rand64());
		send_word(aes_pkg::REQ_ENC, 4'd9, rand64(), rand64());

		send_idle_pct = 33;
		recv_idle_pct = 87;
		random_phase(600);
		send_idle_pct = 87;
		recv_idle_pct = 33;
		random_phase(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holdoff_req = 1'b1;
		random_phase(600);
		in_valid <= 1'b0;

		waited = 0;
		while (outstanding != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
